// ===== hdl/cphp_pkg.sv =====
// Shared definitions for the cookie header pair parser.
// Holds the parse phase type, character and prefix codes, and the result record.
// No dependencies; the top level and the checker import this package.
package cphp_pkg;

   localparam int MAX_HEADER_BYTES_DEF   = 4096;
   localparam int MAX_SESSION_DIGITS_DEF = 16;

   // Field widths of one result beat.
   localparam int OFFSET_W = 12;
   localparam int LENGTH_W = 13;
   localparam int BCD_W    = 64;
   localparam int COUNT_W  = 5;

   // Characters the parser reacts to.
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_SEMI      = 8'h3B;
   localparam logic [7:0] CH_EQUALS    = 8'h3D;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;

   // Progress of the SID= match: 0 to 3 are bytes matched so far.
   localparam logic [2:0] PREFIX_START = 3'd0;
   localparam logic [2:0] PREFIX_DONE  = 3'd4;
   localparam logic [2:0] PREFIX_FAIL  = 3'd7;

   typedef enum logic [5:0] {
      PH_SKIP     = 6'b000001,
      PH_LABEL    = 6'b000010,
      PH_AFTER_EQ = 6'b000100,
      PH_QUOTED   = 6'b001000,
      PH_ESCAPE   = 6'b010000,
      PH_VALUE    = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] pair_offset;
      logic [LENGTH_W-1:0] pair_length;
      logic                value_quoted;
      logic                is_session_id;
      logic [BCD_W-1:0]    session_digits_bcd;
      logic [COUNT_W-1:0]  session_digit_count;
      logic                session_too_long;
      logic                header_too_long;
   } result_type;

   // The n-th character of the text SID=.
   function automatic logic [7:0] sid_char(input logic [1:0] n);
      logic [7:0] c;
      case (n)
         2'd0:    c = 8'h53;
         2'd1:    c = 8'h49;
         2'd2:    c = 8'h44;
         default: c = CH_EQUALS;
      endcase
      return c;
   endfunction

endpackage

// ===== hdl/cphp_if.sv =====
// Valid/ready channel interfaces of the cookie header pair parser.
// One interface carries header bytes in, the other carries pair results out.
// Depends on nothing; field widths follow the block's fixed field list.
interface cphp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] header_byte;
   logic       final_byte;

   modport source (output valid, output header_byte, output final_byte, input ready);
   modport sink   (input valid, input header_byte, input final_byte, output ready);
endinterface

interface cphp_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] pair_offset;
   logic [12:0] pair_length;
   logic        value_quoted;
   logic        is_session_id;
   logic [63:0] session_digits_bcd;
   logic [4:0]  session_digit_count;
   logic        session_too_long;
   logic        header_too_long;

   modport source (output valid, output pair_offset, output pair_length,
                   output value_quoted, output is_session_id,
                   output session_digits_bcd, output session_digit_count,
                   output session_too_long, output header_too_long, input ready);
   modport sink   (input valid, input pair_offset, input pair_length,
                   input value_quoted, input is_session_id,
                   input session_digits_bcd, input session_digit_count,
                   input session_too_long, input header_too_long, output ready);
endinterface

// ===== hdl/cookie_header_pair_parser.sv =====
// Top level of the cookie header pair parser.
// Depends on cphp_pkg and the channel interfaces in cphp_if.sv.
//
// The parser takes an HTTP cookie header one byte per beat on the request
// channel, with final_byte marking the last byte of a header, and gives one
// beat on the response channel for each label=value pair it finds. Spaces,
// tabs and semicolons between pairs are skipped; the label runs to the first
// equals sign, a double-quoted value runs to its closing quote with backslash
// escapes, and a pair ends at a semicolon or at the end of the header. Each
// response gives the pair's offset and length, whether the value was quoted,
// whether the pair begins with SID=, and the leading decimal digits after
// SID= in BCD with a count and an overflow flag. The block takes one byte
// every clock: the parse state updates in the cycle a byte is accepted and
// the result lands in the output register, visible on the response channel
// in the cycle after the byte that closed the pair. The request side stalls
// only while a held result is not taken, since the single output register
// is the only buffering. After a final byte the parse state returns to its
// reset value, so the next byte starts a new header at position zero. Byte
// positions saturate at MAX_HEADER_BYTES, and header_too_long then flags
// the pairs that reach that limit.
module cookie_header_pair_parser #(
   parameter int MAX_HEADER_BYTES   = cphp_pkg::MAX_HEADER_BYTES_DEF,
   parameter int MAX_SESSION_DIGITS = cphp_pkg::MAX_SESSION_DIGITS_DEF
) (
   input logic          clock,
   input logic          reset,
   cphp_req_if.sink     req_chan,
   cphp_rsp_if.source   rsp_chan
);
   import cphp_pkg::*;

   // The position counter has to hold the saturation value itself.
   localparam int PW = $clog2(MAX_HEADER_BYTES + 1);
   localparam int SW = $clog2(MAX_HEADER_BYTES);
   localparam int LW = (PW > LENGTH_W) ? PW : LENGTH_W;
   localparam int OW = (SW > OFFSET_W) ? SW : OFFSET_W;

   // Parse state.
   phase_type          phase_ff,    phase_in;
   logic [PW-1:0]      pos_ff,      pos_in;
   logic [SW-1:0]      start_ff,    start_in;
   logic [2:0]         prefix_ff,   prefix_in;
   logic               capture_ff,  capture_in;
   logic [BCD_W-1:0]   acc_ff,      acc_in;
   logic [COUNT_W-1:0] count_ff,    count_in;
   logic               overflow_ff, overflow_in;
   logic               quote_ff,    quote_in;
   logic               sat_ff,      sat_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         result_ff,    result_in;

   logic [7:0]         b;
   logic               fin;
   logic               req_fire;
   logic               at_limit;
   logic [PW-1:0]      pos_step;
   logic               feed_pair;
   logic               ends_here;
   logic               emit;
   logic [PW-1:0]      end_pos;
   logic [LW-1:0]      length_full;
   logic [OW-1:0]      offset_full;

   assign b        = req_chan.header_byte;
   assign fin      = req_chan.final_byte;
   assign req_fire = req_chan.valid && req_chan.ready;

   // A new byte is taken whenever the output register is free or being emptied.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;

   // Positions stop counting at the limit; a byte there counts as at the limit.
   assign at_limit = (pos_ff == PW'(MAX_HEADER_BYTES));
   assign pos_step = at_limit ? pos_ff : pos_ff + PW'(1);

   always_comb begin
      phase_in    = phase_ff;
      start_in    = start_ff;
      prefix_in   = prefix_ff;
      capture_in  = capture_ff;
      acc_in      = acc_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      quote_in    = quote_ff;
      sat_in      = sat_ff || at_limit;
      feed_pair   = 1'b0;
      ends_here   = 1'b0;

      case (phase_ff)
         PH_LABEL: begin
            feed_pair = 1'b1;
            if (b == CH_EQUALS) begin
               phase_in = PH_AFTER_EQ;
            end
         end
         PH_AFTER_EQ: begin
            if (b == CH_SEMI) begin
               ends_here = 1'b1;
            end else begin
               feed_pair = 1'b1;
               if (b == CH_QUOTE) begin
                  quote_in = 1'b1;
                  phase_in = PH_QUOTED;
               end else if (!(b inside {CH_SPACE, CH_TAB})) begin
                  phase_in = PH_VALUE;
               end
            end
         end
         PH_QUOTED: begin
            feed_pair = 1'b1;
            if (b == CH_BACKSLASH) begin
               phase_in = PH_ESCAPE;
            end else if (b == CH_QUOTE) begin
               phase_in = PH_VALUE;
            end
         end
         PH_ESCAPE: begin
            feed_pair = 1'b1;
            phase_in  = PH_QUOTED;
         end
         PH_VALUE: begin
            if (b == CH_SEMI) begin
               ends_here = 1'b1;
            end else begin
               feed_pair = 1'b1;
            end
         end
         default: begin
            // Skipping separators; any other byte opens a new pair.
            if (!(b inside {CH_SPACE, CH_TAB, CH_SEMI})) begin
               prefix_in   = PREFIX_START;
               capture_in  = 1'b0;
               acc_in      = '0;
               count_in    = '0;
               overflow_in = 1'b0;
               quote_in    = 1'b0;
               start_in    = at_limit ? SW'(MAX_HEADER_BYTES - 1) : pos_ff[SW-1:0];
               feed_pair   = 1'b1;
               phase_in    = (b == CH_EQUALS) ? PH_AFTER_EQ : PH_LABEL;
            end else begin
               phase_in = PH_SKIP;
            end
         end
      endcase

      // Pair text goes through the SID= match and then the digit capture.
      if (feed_pair) begin
         if (prefix_in < PREFIX_DONE) begin
            if (b == sid_char(prefix_in[1:0])) begin
               prefix_in = prefix_in + 3'd1;
               if (prefix_in == PREFIX_DONE) begin
                  capture_in = 1'b1;
               end
            end else begin
               prefix_in = PREFIX_FAIL;
            end
         end else if (prefix_in == PREFIX_DONE && capture_in) begin
            if (b inside {[CH_ZERO:CH_NINE]}) begin
               if (count_in < COUNT_W'(MAX_SESSION_DIGITS)) begin
                  acc_in   = {acc_in[BCD_W-5:0], b[3:0]};
                  count_in = count_in + COUNT_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
            end else begin
               capture_in = 1'b0;
            end
         end
      end

      // A pair ends at its semicolon, or at the final byte once past the sign.
      emit    = ends_here ||
                (fin && (phase_in inside {PH_AFTER_EQ, PH_QUOTED, PH_ESCAPE, PH_VALUE}));
      end_pos = ends_here ? pos_ff : pos_step;

      length_full = LW'(end_pos) - LW'(start_in);
      offset_full = OW'(start_in);

      result_in.pair_offset         = offset_full[OFFSET_W-1:0];
      result_in.pair_length         = length_full[LENGTH_W-1:0];
      result_in.value_quoted        = quote_in;
      result_in.is_session_id       = (prefix_in == PREFIX_DONE);
      result_in.session_digits_bcd  = (prefix_in == PREFIX_DONE) ? acc_in : '0;
      result_in.session_digit_count = (prefix_in == PREFIX_DONE) ? count_in : '0;
      result_in.session_too_long    = (prefix_in == PREFIX_DONE) && overflow_in;
      result_in.header_too_long     = sat_in;

      if (ends_here) begin
         phase_in = PH_SKIP;
      end
      pos_in = pos_step;

      // The end of a header brings everything back to its reset value.
      if (fin) begin
         phase_in    = PH_SKIP;
         pos_in      = '0;
         start_in    = '0;
         prefix_in   = PREFIX_START;
         capture_in  = 1'b0;
         acc_in      = '0;
         count_in    = '0;
         overflow_in = 1'b0;
         quote_in    = 1'b0;
         sat_in      = 1'b0;
      end
   end

   always_comb begin
      if (req_fire && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SKIP;
         pos_ff       <= '0;
         start_ff     <= '0;
         prefix_ff    <= PREFIX_START;
         capture_ff   <= 1'b0;
         acc_ff       <= '0;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         quote_ff     <= 1'b0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            phase_ff    <= phase_in;
            pos_ff      <= pos_in;
            start_ff    <= start_in;
            prefix_ff   <= prefix_in;
            capture_ff  <= capture_in;
            acc_ff      <= acc_in;
            count_ff    <= count_in;
            overflow_ff <= overflow_in;
            quote_ff    <= quote_in;
            sat_ff      <= sat_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.pair_offset         = result_ff.pair_offset;
   assign rsp_chan.pair_length         = result_ff.pair_length;
   assign rsp_chan.value_quoted        = result_ff.value_quoted;
   assign rsp_chan.is_session_id       = result_ff.is_session_id;
   assign rsp_chan.session_digits_bcd  = result_ff.session_digits_bcd;
   assign rsp_chan.session_digit_count = result_ff.session_digit_count;
   assign rsp_chan.session_too_long    = result_ff.session_too_long;
   assign rsp_chan.header_too_long     = result_ff.header_too_long;

endmodule

// ===== hdl/cphp_checker.sv =====
// Port-level assertions for the cookie header pair parser, and their binding.
// Depends on cphp_pkg for parameter defaults; attaches to cookie_header_pair_parser.
module cphp_checker #(
   parameter int MAX_SESSION_DIGITS = cphp_pkg::MAX_SESSION_DIGITS_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [11:0] rsp_pair_offset,
   input logic [12:0] rsp_pair_length,
   input logic        rsp_is_session_id,
   input logic [63:0] rsp_session_digits_bcd,
   input logic [4:0]  rsp_session_digit_count,
   input logic        rsp_session_too_long
);
   import cphp_pkg::*;

   // No result survives a reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat visible right after reset");

   // A held result that is not taken blocks the next header byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("byte accepted while the output register is full and stalled");

   // A stalled result keeps its beat.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pair_offset)
         && $stable(rsp_pair_length) && $stable(rsp_session_digits_bcd))
      else $error("stalled result beat changed");

   // Session fields are only filled for pairs that start with SID=.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_session_id |-> rsp_session_digits_bcd == '0
         && rsp_session_digit_count == '0 && !rsp_session_too_long)
      else $error("session fields set on a pair without SID=");

   // The digit count never exceeds the capture depth.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_session_digit_count <= COUNT_W'(MAX_SESSION_DIGITS))
      else $error("session digit count above its limit");

endmodule

bind cookie_header_pair_parser cphp_checker #(
   .MAX_SESSION_DIGITS (MAX_SESSION_DIGITS)
) u_cphp_checker (
   .clock                   (clock),
   .reset                   (reset),
   .req_ready               (req_chan.ready),
   .rsp_valid               (rsp_chan.valid),
   .rsp_ready               (rsp_chan.ready),
   .rsp_pair_offset         (rsp_chan.pair_offset),
   .rsp_pair_length         (rsp_chan.pair_length),
   .rsp_is_session_id       (rsp_chan.is_session_id),
   .rsp_session_digits_bcd  (rsp_chan.session_digits_bcd),
   .rsp_session_digit_count (rsp_chan.session_digit_count),
   .rsp_session_too_long    (rsp_chan.session_too_long)
);
